/* sv/slst_pkg.sv */
package slst_pkg;

    localparam int unsigned MaxStagesDefault = 16;
    localparam int unsigned CountW = 32;
    localparam int unsigned LatW = 31;
    localparam int unsigned SampleW = 32;
    localparam int unsigned IdxW = 4;
    localparam int unsigned CfgW = 5;

    localparam logic [1:0] OpRecord = 2'd0;
    localparam logic [1:0] OpRead = 2'd1;
    localparam logic [1:0] OpClrFrame = 2'd2;
    localparam logic [1:0] OpClrAll = 2'd3;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StBadStage = 2'd1;
    localparam logic [1:0] StBadSample = 2'd2;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [LatW-1:0] mean;
        logic [LatW-1:0] min;
        logic [LatW-1:0] max;
        logic [LatW-1:0] last;
    } t_stats;

    typedef struct packed {
        logic [1:0] status;
        t_stats stats;
        logic [LatW-1:0] frame;
    } t_result;

endpackage

/* sv/slst_if.sv */
interface slst_in_if
    import slst_pkg::*;
();
    logic valid;
    logic ready;
    logic [1:0] op;
    logic [IdxW-1:0] stage_index;
    logic signed [SampleW-1:0] sample;

    modport source(output valid, op, stage_index, sample, input ready);
    modport sink(input valid, op, stage_index, sample, output ready);
endinterface

interface slst_out_if
    import slst_pkg::*;
();
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [CountW-1:0] sample_count;
    logic [LatW-1:0] mean_latency;
    logic [LatW-1:0] min_latency;
    logic [LatW-1:0] max_latency;
    logic [LatW-1:0] last_latency;
    logic [LatW-1:0] frame_latency;

    modport source(output valid, status, sample_count, mean_latency, min_latency,
        max_latency, last_latency, frame_latency, input ready);
    modport sink(input valid, status, sample_count, mean_latency, min_latency,
        max_latency, last_latency, frame_latency, output ready);
endinterface

/* sv/stage_latency_stats_table.sv */
// Channel | Dir | Beat contents
// i_in    | in  | op, stage_index, sample
// o_out   | out | status, sample_count, mean/min/max/last/frame_latency
// cfg     | in  | i_cfg_we, i_cfg_data (stages_in_use)
// A record with an earlier sample also passes through the 31-step divider; any
// other item goes through accept, table read and write-back only.
// One item is in flight at a time; the output register frees the input side
// while a result waits. Reset is synchronous and clears every statistic via
// per-entry valid bits, so no clearing pass is needed.
module stage_latency_stats_table
    import slst_pkg::*;
#(
    parameter int unsigned MAX_STAGES = MaxStagesDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [CfgW-1:0] i_cfg_data,
    slst_in_if.sink i_in,
    slst_out_if.source o_out
);

    localparam int unsigned AW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    t_stats r_stats_mem [MAX_STAGES];
    logic [LatW-1:0] r_frame_mem [MAX_STAGES];
    logic [MAX_STAGES-1:0] r_stats_vld;
    logic [MAX_STAGES-1:0] r_frame_vld;

    logic [1:0] r_state;
    logic [CfgW-1:0] r_siu;
    logic [1:0] r_op;
    logic [IdxW-1:0] r_idx;
    logic [SampleW-1:0] r_sample;
    t_stats r_rd_stats;
    logic [LatW-1:0] r_rd_frame;
    logic r_rd_svld;
    logic r_rd_fvld;
    logic r_out_valid;
    t_result r_out;

    logic [AW+IdxW-1:0] n_wide_idx;
    logic [AW-1:0] n_addr;
    logic [AW+IdxW-1:0] n_in_wide;
    logic [AW-1:0] n_in_addr;
    logic n_stage_ok;
    logic [LatW-1:0] n_x;
    logic n_neg;
    t_stats n_ent;
    logic [LatW-1:0] n_frm;
    logic n_do_div;
    logic [LatW-1:0] n_mag;
    logic [CountW:0] n_divisor;
    logic n_div_busy;
    logic [LatW-1:0] n_quot;
    logic signed [LatW+2:0] n_mean_s;
    t_stats n_upd;
    t_result n_res;
    logic n_finish;
    logic n_accept;

    assign n_in_wide = {{AW{1'b0}}, i_in.stage_index};
    assign n_in_addr = n_in_wide[AW-1:0];
    assign n_wide_idx = {{AW{1'b0}}, r_idx};
    assign n_addr = n_wide_idx[AW-1:0];
    assign n_stage_ok = ({1'b0, r_idx} < r_siu)
        && ({{AW{1'b0}}, r_idx} < (AW+IdxW)'(MAX_STAGES));
    assign n_x = r_sample[LatW-1:0];
    assign n_neg = r_sample[SampleW-1];
    assign n_ent = r_rd_svld ? r_rd_stats : '0;
    assign n_frm = r_rd_fvld ? r_rd_frame : '0;
    assign n_accept = i_in.valid && i_in.ready;
    assign i_in.ready = r_state == S_IDLE;

    assign n_do_div = (r_op == OpRecord) && n_stage_ok && !n_neg && (n_ent.count != '0);
    assign n_mag = (n_x >= n_ent.mean) ? LatW'(n_x - n_ent.mean) : LatW'(n_ent.mean - n_x);
    assign n_divisor = {1'b0, n_ent.count} + 1'b1;

    slst_div u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_READ && n_do_div),
        .i_dividend(n_mag),
        .i_divisor(n_divisor),
        .o_busy(n_div_busy),
        .o_quotient(n_quot)
    );

    always_comb begin
        n_mean_s = (n_x >= n_ent.mean)
            ? $signed({3'b0, n_ent.mean}) + $signed({3'b0, n_quot})
            : $signed({3'b0, n_ent.mean}) - $signed({3'b0, n_quot});
        n_upd = n_ent;
        if (n_ent.count == '0) begin
            n_upd.mean = n_x;
            n_upd.min = n_x;
            n_upd.max = n_x;
        end else begin
            if (n_mean_s < 0) begin
                n_upd.mean = '0;
            end else if (n_mean_s > $signed({3'b0, {LatW{1'b1}}})) begin
                n_upd.mean = '1;
            end else begin
                n_upd.mean = n_mean_s[LatW-1:0];
            end
            if (n_x < n_ent.min) n_upd.min = n_x;
            if (n_x > n_ent.max) n_upd.max = n_x;
        end
        n_upd.last = n_x;
        if (n_ent.count != '1) n_upd.count = n_ent.count + 1'b1;

        n_res = '0;
        unique case (r_op)
            OpRecord: begin
                if (!n_stage_ok) begin
                    n_res.status = StBadStage;
                end else if (n_neg) begin
                    n_res.status = StBadSample;
                end else begin
                    n_res.stats = n_upd;
                    n_res.frame = n_x;
                end
            end
            OpRead: begin
                if (!n_stage_ok) begin
                    n_res.status = StBadStage;
                end else begin
                    n_res.stats = n_ent;
                    n_res.frame = n_frm;
                end
            end
            default: n_res.status = StOk;
        endcase
    end

    assign n_finish = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_siu <= '0;
            r_out_valid <= 1'b0;
            r_stats_vld <= '0;
            r_frame_vld <= '0;
        end else begin
            if (i_cfg_we) r_siu <= i_cfg_data;
            r_out_valid <= n_finish || (r_out_valid && !o_out.ready);
            unique case (r_state)
                S_IDLE: if (n_accept) r_state <= S_READ;
                S_READ: r_state <= n_do_div ? S_DIV : S_DONE;
                S_DIV: if (!n_div_busy) r_state <= S_DONE;
                S_DONE: begin
                    if (n_finish) begin
                        r_state <= S_IDLE;
                        if (r_op == OpRecord && n_stage_ok && !n_neg) begin
                            r_stats_vld[n_addr] <= 1'b1;
                            r_frame_vld[n_addr] <= 1'b1;
                        end
                        if (r_op == OpClrFrame) r_frame_vld <= '0;
                        if (r_op == OpClrAll) begin
                            for (int i = 0; i < MAX_STAGES; i++) begin
                                if (i < int'(r_siu)) r_stats_vld[i] <= 1'b0;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_op <= i_in.op;
            r_idx <= i_in.stage_index;
            r_sample <= i_in.sample;
            r_rd_stats <= r_stats_mem[n_in_addr];
            r_rd_frame <= r_frame_mem[n_in_addr];
            r_rd_svld <= r_stats_vld[n_in_addr];
            r_rd_fvld <= r_frame_vld[n_in_addr];
        end
        if (n_finish) begin
            r_out <= n_res;
            if (r_op == OpRecord && n_stage_ok && !n_neg) begin
                r_stats_mem[n_addr] <= n_upd;
                r_frame_mem[n_addr] <= n_x;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.status = r_out.status;
    assign o_out.sample_count = r_out.stats.count;
    assign o_out.mean_latency = r_out.stats.mean;
    assign o_out.min_latency = r_out.stats.min;
    assign o_out.max_latency = r_out.stats.max;
    assign o_out.last_latency = r_out.stats.last;
    assign o_out.frame_latency = r_out.frame;

endmodule

/* sv/slst_div.sv */
module slst_div
    import slst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [LatW-1:0] i_dividend,
    input  logic [CountW:0] i_divisor,
    output logic o_busy,
    output logic [LatW-1:0] o_quotient
);

    localparam int unsigned CntW = $clog2(LatW + 1);

    logic [CntW-1:0] r_cnt;
    logic [CountW:0] r_rem;
    logic [CountW:0] r_dvs;
    logic [LatW-1:0] r_q;
    logic [CountW+1:0] n_shift;
    logic n_ge;

    assign n_shift = {r_rem, r_q[LatW-1]};
    assign n_ge = n_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntW'(LatW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_ge ? (CountW+1)'(n_shift - {1'b0, r_dvs}) : n_shift[CountW:0];
            r_q <= {r_q[LatW-2:0], n_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quotient = r_q;

endmodule
